/* hdl/pva_pkg.sv */
// ----------------------------------------------------------------------------
// pva_pkg
// shared types and constants of the priority voice allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  localparam int NUM_VOICES = 24;
  localparam int PRI_W      = 15;
  localparam int STATUS_W   = 2;
  localparam int ENTRY_W    = 5;   // width of the voice number fields on the ports
  localparam int KIND_W     = 2;

  localparam int CLOG_V  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  // internal voice number, never narrower than the port field so compares are exact
  localparam int VIDX_W  = (CLOG_V > ENTRY_W) ? CLOG_V : ENTRY_W;
  localparam int CNT_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam logic [PRI_W-1:0] PRI_CEILING  = 15'h7FFF;
  localparam logic [PRI_W-1:0] PRI_SATURATE = 15'h7FFE;

  localparam logic [STATUS_W-1:0] ST_FREE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TAKEN   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SUSTAIN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASE = 2'd3;

  localparam logic [KIND_W-1:0] GK_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] GK_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] GK_RELEASE = 2'd2;
  localparam logic [KIND_W-1:0] GK_SUSTAIN = 2'd3;

  // running search result handed from cell to cell
  typedef struct packed {
    logic              free_found;
    logic [VIDX_W-1:0] free_idx;
    logic              rel_found;
    logic [PRI_W-1:0]  rel_pri;
    logic [VIDX_W-1:0] rel_idx;
    logic              sus_found;
    logic [PRI_W-1:0]  sus_pri;
    logic [VIDX_W-1:0] sus_idx;
  } scan_rec_t;

  // update broadcast to every cell
  typedef struct packed {
    logic                wr;        // overwrite the whole entry
    logic                take;      // claim the entry
    logic                take_free; // claim also moves status to taken
    logic [VIDX_W-1:0]   idx;
    logic [STATUS_W-1:0] status;
    logic [PRI_W-1:0]    pri;
    logic                locked;
    logic                claimed;
  } cell_cmd_t;

  localparam scan_rec_t SCAN_INIT = '{
    free_found: 1'b0,
    free_idx:   '0,
    rel_found:  1'b0,
    rel_pri:    PRI_CEILING,
    rel_idx:    '0,
    sus_found:  1'b0,
    sus_pri:    PRI_CEILING,
    sus_idx:    '0
  };

endpackage

`default_nettype wire

/* hdl/priority_voice_allocator.sv */
// ----------------------------------------------------------------------------
// priority_voice_allocator
// voice allocator with priority based stealing over a chain of voice cells
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: tuser selects allocate (0) or write-entry (1),
//   tdata carries the request priority and the entry fields.
//   m_* returns one result transfer per request: tdata holds granted and
//   the voice number, tuser holds the grant kind.
//   A write-entry updates its voice at the accepting edge and its result is
//   presented in the next cycle. An allocate request runs the search record
//   down the row of NUM_VOICES cells, one cell per cycle, and is decided in
//   the last cycle of the scan; its result is then registered in the output
//   register and presented. One request is in work at a time, so no new
//   request is taken while an allocate scans.
//   Reset frees every voice and clears priority, lock and claim marks;
//   s_tready stays low while reset is held.
//   A stalled result stays in the output register; a new request is taken
//   once the result is gone or is being taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_voice_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // request_priority, entry_index, entry_status, entry_priority,
  // entry_locked, entry_claimed, zero pad
  input  wire logic [39:0] s_tdata,
  // func
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // granted, granted_voice, zero pad
  output logic [7:0]       m_tdata,
  // grant_kind
  output logic [1:0]       m_tuser
);
  import pva_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic [PRI_W-1:0]    req_pri;
  logic                out_granted;
  logic [ENTRY_W-1:0]  out_voice;
  logic [KIND_W-1:0]   out_kind;

  logic                func;
  logic [PRI_W-1:0]    in_req;
  logic [ENTRY_W-1:0]  in_idx;
  logic [STATUS_W-1:0] in_status;
  logic [PRI_W-1:0]    in_pri;
  logic                in_locked;
  logic                in_claimed;
  logic                s_xfer;
  logic                scan_done;

  scan_rec_t           rec [NUM_VOICES+1];
  cell_cmd_t           cmd;
  logic                dec_grant;
  logic [VIDX_W-1:0]   dec_idx;
  logic [KIND_W-1:0]   dec_kind;

  assign func       = s_tuser[0];
  assign in_req     = s_tdata[14:0];
  assign in_idx     = s_tdata[19:15];
  assign in_status  = s_tdata[21:20];
  assign in_pri     = s_tdata[36:22];
  assign in_locked  = s_tdata[37];
  assign in_claimed = s_tdata[38];

  assign s_tready  = !rst && (state == S_IDLE) && (!m_tvalid || m_tready);
  assign s_xfer    = s_tvalid && s_tready;
  assign scan_done = (state == S_SCAN) && (cnt == CNT_W'(NUM_VOICES - 1));

  // row of voice cells, search record enters at the low end
  assign rec[0] = SCAN_INIT;
  for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
    pva_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .my_idx (VIDX_W'(i)),
      .cmd    (cmd),
      .rec_in (rec[i]),
      .rec_out(rec[i+1])
    );
  end

  // decision on the record leaving the last cell
  always_comb begin
    dec_grant = 1'b0;
    dec_idx   = '0;
    dec_kind  = GK_NONE;
    if (rec[NUM_VOICES].free_found) begin
      dec_grant = 1'b1;
      dec_idx   = rec[NUM_VOICES].free_idx;
      dec_kind  = GK_FREE;
    end else if (rec[NUM_VOICES].rel_found && (req_pri >= rec[NUM_VOICES].rel_pri)) begin
      dec_grant = 1'b1;
      dec_idx   = rec[NUM_VOICES].rel_idx;
      dec_kind  = GK_RELEASE;
    end else if (rec[NUM_VOICES].sus_found && (req_pri >= rec[NUM_VOICES].sus_pri)) begin
      dec_grant = 1'b1;
      dec_idx   = rec[NUM_VOICES].sus_idx;
      dec_kind  = GK_SUSTAIN;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.status    = in_status;
    cmd.pri       = in_pri;
    cmd.locked    = in_locked;
    cmd.claimed   = in_claimed;
    if (scan_done) begin
      cmd.take      = dec_grant;
      cmd.take_free = (dec_kind == GK_FREE);
      cmd.idx       = dec_idx;
    end else begin
      cmd.wr  = s_xfer && func;
      cmd.idx = VIDX_W'(in_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_xfer) begin
            if (func) begin
              m_tvalid <= 1'b1;
            end else begin
              state <= S_SCAN;
              cnt   <= '0;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (scan_done) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      req_pri     <= (in_req > PRI_SATURATE) ? PRI_SATURATE : in_req;
      out_granted <= 1'b0;
      out_voice   <= '0;
      out_kind    <= GK_NONE;
    end else if (scan_done) begin
      out_granted <= dec_grant;
      out_voice   <= dec_idx[ENTRY_W-1:0];
      out_kind    <= dec_kind;
    end
  end

  assign m_tdata = {2'b00, out_voice, out_granted};
  assign m_tuser = out_kind;

endmodule

`default_nettype wire

/* hdl/pva_cell.sv */
// ----------------------------------------------------------------------------
// pva_cell
// one voice entry plus one stage of the search chain
// ----------------------------------------------------------------------------
`default_nettype none

module pva_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [pva_pkg::VIDX_W-1:0] my_idx,
  input  wire pva_pkg::cell_cmd_t        cmd,
  input  wire pva_pkg::scan_rec_t        rec_in,
  output pva_pkg::scan_rec_t             rec_out
);
  import pva_pkg::*;

  logic [STATUS_W-1:0] status;
  logic [PRI_W-1:0]    pri;
  logic                locked;
  logic                claimed;
  scan_rec_t           rec_next;
  logic                hit;

  assign hit = (cmd.idx == my_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      status  <= ST_FREE;
      pri     <= '0;
      locked  <= 1'b0;
      claimed <= 1'b0;
    end else if (cmd.wr && hit) begin
      status  <= cmd.status;
      pri     <= cmd.pri;
      locked  <= cmd.locked;
      claimed <= cmd.claimed;
    end else if (cmd.take && hit) begin
      claimed <= 1'b1;
      if (cmd.take_free) begin
        status <= ST_TAKEN;
      end
    end
  end

  always_comb begin
    rec_next = rec_in;
    // once a free voice is seen upstream the rest of the chain just passes it on
    if (!rec_in.free_found && !locked) begin
      if (status == ST_FREE) begin
        rec_next.free_found = 1'b1;
        rec_next.free_idx   = my_idx;
      end else if (status == ST_SUSTAIN) begin
        if (pri < rec_in.sus_pri) begin
          rec_next.sus_found = 1'b1;
          rec_next.sus_pri   = pri;
          rec_next.sus_idx   = my_idx;
        end
      end else begin
        if (pri < rec_in.rel_pri) begin
          rec_next.rel_found = 1'b1;
          rec_next.rel_pri   = pri;
          rec_next.rel_idx   = my_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_out <= rec_next;
  end

endmodule

`default_nettype wire

/* sim/priority_voice_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_voice_allocator_tb
// self-checking bench: drives allocate and write-entry requests, keeps its own
// copy of the voice table to predict every grant, and compares each result
// transfer against the oldest prediction under random idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module priority_voice_allocator_tb;
  import pva_pkg::*;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;
  localparam int   WATCHDOG_LIMIT = 3000;
  localparam int   TAIL_CYCLES = 2 * NUM_VOICES + 8;
  localparam int   MAX_PRINTS = 40;

  typedef struct packed {
    logic                func;
    logic [PRI_W-1:0]    req_pri;
    logic [ENTRY_W-1:0]  idx;
    logic [STATUS_W-1:0] status;
    logic [PRI_W-1:0]    pri;
    logic                locked;
    logic                claimed;
  } voice_req_t;

  typedef struct {
    logic               granted;
    logic [ENTRY_W-1:0] voice;
    logic [KIND_W-1:0]  kind;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // request_priority, entry_index, entry_status, entry_priority,
  // entry_locked, entry_claimed, zero pad
  logic [39:0] s_tdata = '0;
  // func
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // granted, granted_voice, zero pad
  logic [7:0]  m_tdata;
  // grant_kind
  logic [1:0]  m_tuser;

  // shadow voice table
  logic [STATUS_W-1:0] tbl_status [NUM_VOICES];
  logic [PRI_W-1:0]    tbl_pri    [NUM_VOICES];
  logic                tbl_lock   [NUM_VOICES];
  logic                tbl_claim  [NUM_VOICES];

  grant_t pending_grants[$];
  int     err_count = 0;
  int     result_count = 0;
  bit     tx_idle_en = 1'b1;
  bit     rx_idle_en = 1'b1;
  bit     hold_req = 1'b0;
  int     hold_req_len = 0;

  priority_voice_allocator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    else if (r < 95) return $urandom_range(3, 8);
    else return $urandom_range(15, 50);
  endfunction

  // priorities lean on the extremes and on a narrow band that makes ties
  function automatic logic [PRI_W-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    else if (r < 16) return PRI_CEILING;
    else if (r < 24) return PRI_SATURATE;
    else if (r < 55) return PRI_W'($urandom_range(0, 15));
    else return PRI_W'($urandom_range(0, 32767));
  endfunction

  function automatic grant_t predict_grant(input voice_req_t r);
    grant_t           g;
    logic [PRI_W-1:0] req;
    logic [PRI_W-1:0] rel_pri;
    logic [PRI_W-1:0] sus_pri;
    int               rel_idx;
    int               sus_idx;
    bit               rel_found;
    bit               sus_found;
    g = '{granted: 1'b0, voice: '0, kind: GK_NONE};
    if (r.func == FUNC_WRITE) begin
      if (r.idx < NUM_VOICES) begin
        tbl_status[r.idx] = r.status;
        tbl_pri[r.idx]    = r.pri;
        tbl_lock[r.idx]   = r.locked;
        tbl_claim[r.idx]  = r.claimed;
      end
      return g;
    end
    req = (r.req_pri > PRI_SATURATE) ? PRI_SATURATE : r.req_pri;
    rel_pri = PRI_CEILING;
    sus_pri = PRI_CEILING;
    rel_idx = 0;
    sus_idx = 0;
    rel_found = 1'b0;
    sus_found = 1'b0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      if (!tbl_lock[v]) begin
        if (tbl_status[v] == ST_FREE) begin
          tbl_status[v] = ST_TAKEN;
          tbl_claim[v] = 1'b1;
          g = '{granted: 1'b1, voice: ENTRY_W'(v), kind: GK_FREE};
          return g;
        end else if (tbl_status[v] == ST_SUSTAIN) begin
          if (tbl_pri[v] < sus_pri) begin
            sus_pri = tbl_pri[v];
            sus_idx = v;
            sus_found = 1'b1;
          end
        end else if (tbl_pri[v] < rel_pri) begin
          rel_pri = tbl_pri[v];
          rel_idx = v;
          rel_found = 1'b1;
        end
      end
    end
    if (rel_found && req >= rel_pri) begin
      tbl_claim[rel_idx] = 1'b1;
      g = '{granted: 1'b1, voice: ENTRY_W'(rel_idx), kind: GK_RELEASE};
    end else if (sus_found && req >= sus_pri) begin
      tbl_claim[sus_idx] = 1'b1;
      g = '{granted: 1'b1, voice: ENTRY_W'(sus_idx), kind: GK_SUSTAIN};
    end
    return g;
  endfunction

  function automatic voice_req_t alloc_req(input logic [PRI_W-1:0] pri);
    voice_req_t r;
    r = voice_req_t'({$urandom, $urandom});
    r.func = FUNC_ALLOC;
    r.req_pri = pri;
    return r;
  endfunction

  function automatic voice_req_t write_req(input int idx, input logic [STATUS_W-1:0] st,
                                           input logic [PRI_W-1:0] pri, input logic lk,
                                           input logic cl);
    voice_req_t r;
    r = voice_req_t'({$urandom, $urandom});
    r.func = FUNC_WRITE;
    r.idx = ENTRY_W'(idx);
    r.status = st;
    r.pri = pri;
    r.locked = lk;
    r.claimed = cl;
    return r;
  endfunction

  function automatic voice_req_t random_req(input int write_pct);
    voice_req_t r;
    r = voice_req_t'({$urandom, $urandom});
    r.func = ($urandom_range(0, 99) < write_pct) ? FUNC_WRITE : FUNC_ALLOC;
    r.req_pri = pick_priority();
    r.pri = pick_priority();
    r.idx = ($urandom_range(0, 9) == 0) ? ENTRY_W'($urandom_range(NUM_VOICES, 31))
                                        : ENTRY_W'($urandom_range(0, NUM_VOICES - 1));
    r.locked = ($urandom_range(0, 99) < 15);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("%0t: result %0d %s: got %0d, expected %0d", $time, result_count, what, got,
               want);
  endtask

  // called at a rising edge, returns at the edge that completes the transfer
  task automatic send_request(input voice_req_t r);
    int gap;
    bit taken;
    gap = (tx_idle_en && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.func;
    s_tdata  <= {1'b0, r.claimed, r.locked, r.pri, r.status, r.idx, r.req_pri};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    pending_grants.push_back(predict_grant(r));
  endtask

  task automatic wait_results_drained();
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // result checker: outputs are stable at the falling edge before the transfer
  initial begin
    grant_t want;
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("with no request outstanding, tdata", m_tdata, 0);
        end else begin
          want = pending_grants.pop_front();
          if (m_tdata[0] !== want.granted) report_mismatch("granted", m_tdata[0], want.granted);
          if (m_tdata[5:1] !== want.voice) report_mismatch("granted_voice", m_tdata[5:1],
                                                           want.voice);
          if (m_tuser !== want.kind) report_mismatch("grant_kind", m_tuser, want.kind);
        end
        result_count++;
      end
    end
  end

  // result side ready, with random gaps and a long hold-off on request
  initial begin
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = hold_req_len;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        m_tready <= 1'b0;
        gap_left--;
      end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
        m_tready <= 1'b0;
        gap_left = idle_len() - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any transfer on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // extremes, out of range writes, saturation, ceiling, ties and refusal
  task automatic test_directed();
    logic [STATUS_W-1:0] st;
    logic [PRI_W-1:0]    pri;
    send_request(alloc_req('0));
    send_request(write_req(31, ST_RELEASE, PRI_CEILING, 1'b1, 1'b1));
    send_request(write_req(NUM_VOICES, ST_FREE, '0, 1'b0, 1'b0));
    // every voice busy: sustain, taken at the ceiling, releasing with ties
    for (int v = 0; v < NUM_VOICES; v++) begin
      case (v % 4)
        0: begin
          st = ST_SUSTAIN;
          pri = (v == 4 || v == 8) ? PRI_W'(200) : PRI_W'(7000);
        end
        1: begin
          st = ST_TAKEN;
          pri = PRI_CEILING;
        end
        2: begin
          st = ST_RELEASE;
          pri = PRI_W'(500);
        end
        default: begin
          st = ST_SUSTAIN;
          pri = PRI_W'(9000);
        end
      endcase
      send_request(write_req(v, st, pri, v == 2, v[0]));
    end
    send_request(alloc_req(PRI_CEILING));
    send_request(alloc_req(PRI_W'(100)));
    send_request(alloc_req(PRI_W'(200)));
    send_request(alloc_req(PRI_W'(499)));
  endtask

  task automatic test_random_mix(input int n);
    for (int i = 0; i < n; i++) send_request(random_req(45));
  endtask

  // result side holds off while requests keep coming, so the input stalls
  task automatic test_output_stall();
    tx_idle_en = 1'b0;
    hold_req_len = 300;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) send_request(random_req(30));
    tx_idle_en = 1'b1;
  endtask

  task automatic test_back_to_back(input int n);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < n; i++) send_request(random_req(50));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // sender stops until every outstanding result is back, then resumes
  task automatic test_drain_pause();
    send_request(random_req(50));
    send_request(alloc_req(PRI_SATURATE));
    s_tvalid <= 1'b0;
    wait_results_drained();
    for (int i = 0; i < 10; i++) send_request(random_req(50));
  endtask

  initial begin
    for (int v = 0; v < NUM_VOICES; v++) begin
      tbl_status[v] = ST_FREE;
      tbl_pri[v]    = '0;
      tbl_lock[v]   = 1'b0;
      tbl_claim[v]  = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(500);
    test_output_stall();
    test_back_to_back(200);
    test_drain_pause();
    test_random_mix(550);
    s_tvalid <= 1'b0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hdl/pva_pkg.sv
hdl/pva_cell.sv
hdl/priority_voice_allocator.sv
sim/priority_voice_allocator_tb.sv
